// ----- design/fqs_pkg.sv -----
// Package for the queue with occupancy statistics.
// Holds the request, result, entry and status types and the command codes.
// No dependencies.
package fqs_pkg;

    // Command codes carried in the request.
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] cart_id;
        logic [7:0]  item_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] head_cart_id;
        logic [7:0]  head_item_count;
        logic [6:0]  occupancy;
        logic [6:0]  high_water;
        logic [13:0] waiting_items;
        logic [31:0] total_items;
        logic [31:0] served_count;
        logic        is_empty;
    } t_res;

    // One slot of the ring store.
    typedef struct packed {
        logic [15:0] cart_id;
        logic [7:0]  item_count;
    } t_entry;

    // Counter update applied when a command completes.
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [7:0] enq_count;
        logic [7:0] deq_count;
    } t_upd;

    // Statistics as they stand after the completing command.
    typedef struct packed {
        logic [6:0]  occupancy;
        logic [6:0]  high_water;
        logic [13:0] waiting_items;
        logic [31:0] total_items;
        logic [31:0] served_count;
        logic        is_empty;
    } t_stats;

    // Queue condition used to judge the next command.
    typedef struct packed {
        logic full;
        logic empty;
    } t_flags;

endpackage

// ----- design/fqs_ring.sv -----
// Ring store of queue entries: one write port, one registered read port.
// Depends on fqs_pkg for the entry type.
module fqs_ring
    import fqs_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fqs_stats.sv -----
// Occupancy, high-water mark, waiting items and saturating running totals.
// Depends on fqs_pkg for the update, statistics and flag types.
module fqs_stats
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_apply,
    input  t_upd   i_upd,
    output t_stats o_stats,
    output t_flags o_flags
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_peak,  n_peak;
    logic [13:0]   r_items_now,  n_items_now;
    logic [31:0]   r_items_ever, n_items_ever;
    logic [31:0]   r_served,     n_served;
    logic [32:0]   ever_sum;
    logic [32:0]   served_sum;
    logic [31:0]   count_wide;
    logic [31:0]   peak_wide;

    always_comb begin
        n_count      = r_count;
        n_items_now  = r_items_now;
        n_items_ever = r_items_ever;
        n_served     = r_served;
        ever_sum     = 33'(r_items_ever) + 33'(i_upd.enq_count);
        served_sum   = 33'(r_served) + 33'd1;
        if (i_apply && i_upd.enq) begin
            n_count      = r_count + CW'(1);
            n_items_now  = r_items_now + 14'(i_upd.enq_count);
            n_items_ever = ever_sum[32] ? '1 : ever_sum[31:0];
        end else if (i_apply && i_upd.deq) begin
            n_count     = r_count - CW'(1);
            n_items_now = r_items_now - 14'(i_upd.deq_count);
            n_served    = served_sum[32] ? '1 : served_sum[31:0];
        end
        n_peak = (n_count > r_peak) ? n_count : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_peak       <= '0;
            r_items_now  <= '0;
            r_items_ever <= '0;
            r_served     <= '0;
        end else begin
            r_count      <= n_count;
            r_peak       <= n_peak;
            r_items_now  <= n_items_now;
            r_items_ever <= n_items_ever;
            r_served     <= n_served;
        end
    end

    assign count_wide = 32'(n_count);
    assign peak_wide  = 32'(n_peak);

    always_comb begin
        o_stats.occupancy     = count_wide[6:0];
        o_stats.high_water    = peak_wide[6:0];
        o_stats.waiting_items = n_items_now;
        o_stats.total_items   = n_items_ever;
        o_stats.served_count  = n_served;
        o_stats.is_empty      = (n_count == '0);
        o_flags.full          = (r_count == CW'(QUEUE_DEPTH));
        o_flags.empty         = (r_count == '0);
    end

    // The mark never falls below the occupancy it tracks.
    a_peak_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("high-water mark below occupancy");

    // Occupancy stays within the ring.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // A completing dequeue always had an entry to remove.
    a_deq_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_apply && i_upd.deq) |-> (r_count != '0))
        else $error("dequeue applied to empty queue");

endmodule

// ----- design/fifo_queue_with_statistics_core.sv -----
// Top level of the queue with occupancy statistics.
// Depends on fqs_pkg, fqs_ring and fqs_stats.
//
// A request (enqueue, dequeue or peek) is taken at a rising edge where start
// is high and busy is low. The entries live in a ring store built from a
// synchronous memory with a registered read, so each request runs in order:
// in the cycle after acceptance busy is high while the head slot is read, and
// in the cycle after that o_strobe is high for exactly one cycle with the
// result. A new request may be accepted in the same cycle the result is shown,
// but not before, so requests never overlap. The result carries the status, the
// dequeued or peeked entry (zero otherwise) and all statistics as they stand
// after the request. Dequeue or peek on an empty queue returns the empty
// status, enqueue on a full queue returns the full status, and neither
// changes anything. Command code 3 returns an ok status and changes nothing.
// The receiver cannot stall the result; it must take it in that cycle.
module fifo_queue_with_statistics_core
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_request,
    output logic o_strobe,
    output t_res o_result
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic          accept;
    logic          r_busy;
    logic          r_strobe;
    t_res          r_result, n_result;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    t_status       r_status, n_status;
    logic          r_enq_ok, n_enq_ok;
    logic          r_deq_ok, n_deq_ok;
    logic          r_peek_ok, n_peek_ok;
    logic [7:0]    r_enq_count;
    t_entry        wdata;
    t_entry        rdata;
    t_upd          upd;
    t_stats        stats;
    t_flags        flags;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // Judge the request against the queue condition at acceptance.
    always_comb begin
        n_status  = ST_OK;
        n_enq_ok  = 1'b0;
        n_deq_ok  = 1'b0;
        n_peek_ok = 1'b0;
        case (i_request.command)
            CMD_ENQ: begin
                if (flags.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_enq_ok = 1'b1;
                end
            end
            CMD_DEQ: begin
                if (flags.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_deq_ok = 1'b1;
                end
            end
            CMD_PEEK: begin
                if (flags.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_peek_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Pointers move at acceptance; the ring wraps at the last slot.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (accept && n_enq_ok) begin
            n_tail = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);
        end
        if (accept && n_deq_ok) begin
            n_head = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
    end

    assign wdata.cart_id    = i_request.cart_id;
    assign wdata.item_count = i_request.item_count;

    // The enqueue write lands at the acceptance edge, so a later request,
    // which is accepted only once this result is shown, always reads the new data.
    fqs_ring #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && n_enq_ok),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_comb begin
        upd.enq       = r_enq_ok;
        upd.deq       = r_deq_ok;
        upd.enq_count = r_enq_count;
        upd.deq_count = rdata.item_count;
    end

    // Counters are updated in the read cycle, when the head count is known.
    fqs_stats #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (r_busy),
        .i_upd   (upd),
        .o_stats (stats),
        .o_flags (flags)
    );

    always_comb begin
        n_result.status          = r_status;
        n_result.head_cart_id    = '0;
        n_result.head_item_count = '0;
        if (r_deq_ok || r_peek_ok) begin
            n_result.head_cart_id    = rdata.cart_id;
            n_result.head_item_count = rdata.item_count;
        end
        n_result.occupancy     = stats.occupancy;
        n_result.high_water    = stats.high_water;
        n_result.waiting_items = stats.waiting_items;
        n_result.total_items   = stats.total_items;
        n_result.served_count  = stats.served_count;
        n_result.is_empty      = stats.is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_strobe  <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_enq_ok  <= 1'b0;
            r_deq_ok  <= 1'b0;
            r_peek_ok <= 1'b0;
        end else begin
            r_busy    <= accept;
            r_strobe  <= r_busy;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_enq_ok  <= accept && n_enq_ok;
            r_deq_ok  <= accept && n_deq_ok;
            r_peek_ok <= accept && n_peek_ok;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_enq_count <= i_request.item_count;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Every accepted request yields its result in the cycle after the read.
    a_busy_then_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_strobe)
        else $error("read cycle not followed by a result");

    // The read cycle and the result cycle never overlap.
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !r_busy)
        else $error("result shown during a read cycle");

    // At most one kind of successful operation is in flight.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_enq_ok, r_deq_ok, r_peek_ok}))
        else $error("conflicting operations in flight");

    // A successful operation is only ever in its read cycle.
    a_op_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enq_ok || r_deq_ok || r_peek_ok) |-> r_busy)
        else $error("operation flag outside read cycle");

endmodule
